// File: hdl/bbfa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbfa_pkg
// Shared constants, codes and control types of the bitmap best-fit allocator.
// ----------------------------------------------------------------------------
package bbfa_pkg;

  // map geometry
  localparam int MAP_BITS = 64;
  localparam int CNT_W    = $clog2(MAP_BITS);
  localparam int LEN_W    = 7;
  localparam int IDX_W    = 6;
  localparam int OP_W     = 2;
  localparam int CMP_W    = LEN_W + 1;

  // operation codes
  typedef enum logic [OP_W-1:0] {
    OP_WRITE = 2'd0,
    OP_READ  = 2'd1,
    OP_ALLOC = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  // control broadcast to every cell of the ring
  typedef struct packed {
    logic             shift;
    logic             wr_en;
    logic [IDX_W-1:0] wr_idx;
    logic             wr_val;
    logic             mark_en;
    logic [CMP_W-1:0] mark_lo;
    logic [CMP_W-1:0] mark_hi;
  } cell_ctrl_t;

  // best run seen by the scanner
  typedef struct packed {
    logic             have;
    logic [CNT_W-1:0] best_pos;
  } scan_res_t;

endpackage

// File: hdl/bbfa_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbfa_cell
// One map cell: holds one bit, passes it to its neighbor while the ring
// rotates, and takes direct writes and range marks at its home index.
// ----------------------------------------------------------------------------
module bbfa_cell
  import bbfa_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  cell_ctrl_t       ctrl,
  input  logic [CNT_W-1:0] cell_index,
  input  logic             nbr_bit,
  output logic             cell_bit
);

  logic cell_q;
  logic wr_hit;
  logic mark_hit;

  // decode against this cell's home index
  assign wr_hit   = ctrl.wr_en && (CMP_W'(ctrl.wr_idx) == CMP_W'(cell_index));
  assign mark_hit = ctrl.mark_en && (CMP_W'(cell_index) >= ctrl.mark_lo) &&
                    (CMP_W'(cell_index) < ctrl.mark_hi);

  // cell storage
  always_ff @(posedge clk) begin
    if (rst) begin
      cell_q <= 1'b0;
    end else if (ctrl.shift) begin
      cell_q <= nbr_bit;
    end else if (wr_hit) begin
      cell_q <= ctrl.wr_val;
    end else if (mark_hit) begin
      cell_q <= 1'b1;
    end
  end

  assign cell_bit = cell_q;

endmodule

// File: hdl/bbfa_scan.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbfa_scan
// Run tracker at the ring head: sees one cell per cycle while step is high,
// measures free runs, keeps the smallest run that fits, lowest start on ties.
// ----------------------------------------------------------------------------
module bbfa_scan
  import bbfa_pkg::*;
(
  input  logic             clk,
  input  logic             clr,
  input  logic             step,
  input  logic             head_bit,
  input  logic [CNT_W-1:0] pos,
  input  logic [LEN_W-1:0] map_len,
  input  logic [LEN_W-1:0] req_size,
  output scan_res_t        res
);

  logic [LEN_W-1:0] run_len;
  logic [CNT_W-1:0] run_start;
  logic             have;
  logic [LEN_W-1:0] best_len;
  logic [CNT_W-1:0] best_pos;

  logic             free;
  logic             last;
  logic             closing;
  logic             tail;
  logic [LEN_W-1:0] cand_len;
  logic [CNT_W-1:0] cand_start;
  logic             cand_ok;

  // classify the head cell and form the run that ends here, if any
  always_comb begin
    free       = !head_bit && (LEN_W'(pos) < map_len);
    last       = (pos == CNT_W'(MAP_BITS - 1));
    closing    = !free && (run_len != '0);
    tail       = free && last;
    cand_len   = tail ? run_len + LEN_W'(1) : run_len;
    cand_start = (tail && (run_len == '0)) ? pos : run_start;
    cand_ok    = (closing || tail) && (req_size != '0) && (cand_len >= req_size) &&
                 (!have || (cand_len < best_len));
  end

  // run and best-fit registers
  always_ff @(posedge clk) begin
    if (clr) begin
      run_len <= '0;
      have    <= 1'b0;
    end else if (step) begin
      run_len <= free ? run_len + LEN_W'(1) : '0;
      if (free && (run_len == '0)) begin
        run_start <= pos;
      end
      if (cand_ok) begin
        have     <= 1'b1;
        best_len <= cand_len;
        best_pos <= cand_start;
      end
    end
  end

  assign res.have     = have;
  assign res.best_pos = best_pos;

endmodule

// File: hdl/bitmap_best_fit_allocator_core.sv
`timescale 1ns / 1ps
// Sequencing: a write goes straight to the result; a read and an allocate first scan
//   the 64-cell ring through one full rotation past the scanner, and an allocate
//   then marks its run. Flow: one item at a time, taken once the previous result is
//   loaded into the output register, later while a result is stalled.
// Reset: synchronous on rst; every cell is cleared to free and map_length is 64.
// ----------------------------------------------------------------------------
// bitmap_best_fit_allocator_core
// Best-fit allocator over a ring of one-bit cells with a run scanner at its head.
// ----------------------------------------------------------------------------
module bitmap_best_fit_allocator_core
  import bbfa_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // slave stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // bit_index[5:0], bit_value[6], request_size[13:7], zero
  input  logic [1:0]  s_tuser,   // operation[1:0]
  // master stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // position[5:0], bit_read[6], zero
  output logic        m_tuser,   // found
  // configuration write
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [6:0]  cfg_data   // map_length
);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SCAN   = 4'b0010,
    ST_MARK   = 4'b0100,
    ST_RESULT = 4'b1000
  } state_t;

  state_t state, state_next;

  logic [LEN_W-1:0] map_length;
  logic [LEN_W-1:0] len_eff;
  op_t              op;
  logic [IDX_W-1:0] idx;
  logic [LEN_W-1:0] size;
  logic [CNT_W-1:0] pos;
  logic             res_found;
  logic [IDX_W-1:0] res_pos;
  logic             res_rd;

  logic             s_xfer;
  logic             out_free;
  op_t              in_op;
  cell_ctrl_t       ctrl;
  scan_res_t        scan;
  logic [MAP_BITS-1:0] map_bit;

  // configuration register
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      map_length <= LEN_W'(MAP_BITS);
    end else if (cfg_valid) begin
      map_length <= cfg_data;
    end
  end
  assign len_eff = (map_length > LEN_W'(MAP_BITS)) ? LEN_W'(MAP_BITS) : map_length;

  assign s_tready = (state == ST_IDLE);
  assign s_xfer   = s_tvalid && s_tready;
  assign in_op    = op_t'(s_tuser);
  assign out_free = !m_tvalid || m_tready;

  // state sequencing
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (s_xfer) begin
          if (in_op inside {OP_READ, OP_ALLOC}) begin
            state_next = ST_SCAN;
          end else begin
            state_next = ST_RESULT;
          end
        end
      end
      ST_SCAN: begin
        if (pos == CNT_W'(MAP_BITS - 1)) begin
          state_next = (op == OP_ALLOC) ? ST_MARK : ST_RESULT;
        end
      end
      ST_MARK:   state_next = ST_RESULT;
      ST_RESULT: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default:   state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // item capture, scan position and result assembly
  always_ff @(posedge clk) begin
    if (s_xfer) begin
      op        <= in_op;
      idx       <= s_tdata[5:0];
      size      <= s_tdata[13:7];
      pos       <= '0;
      res_found <= 1'b0;
      res_pos   <= '0;
      res_rd    <= 1'b0;
    end else if (state == ST_SCAN) begin
      pos <= pos + CNT_W'(1);
      if ((op == OP_READ) && (CMP_W'(pos) == CMP_W'(idx))) begin
        res_rd <= map_bit[0];
      end
    end else if ((state == ST_MARK) && scan.have) begin
      res_found <= 1'b1;
      res_pos   <= IDX_W'(scan.best_pos);
    end
  end

  // cell control broadcast
  always_comb begin
    ctrl.shift   = (state == ST_SCAN);
    ctrl.wr_en   = s_xfer && (in_op == OP_WRITE);
    ctrl.wr_idx  = s_tdata[5:0];
    ctrl.wr_val  = s_tdata[6];
    ctrl.mark_en = (state == ST_MARK) && scan.have;
    ctrl.mark_lo = CMP_W'(scan.best_pos);
    ctrl.mark_hi = CMP_W'(scan.best_pos) + CMP_W'(size);
  end

  // ring of cells, cell zero at the scanner
  for (genvar i = 0; i < MAP_BITS; i++) begin : g_cell
    bbfa_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (ctrl),
      .cell_index (CNT_W'(i)),
      .nbr_bit    (map_bit[(i + 1) % MAP_BITS]),
      .cell_bit   (map_bit[i])
    );
  end

  bbfa_scan u_scan (
    .clk      (clk),
    .clr      (s_xfer),
    .step     (state == ST_SCAN),
    .head_bit (map_bit[0]),
    .pos      (pos),
    .map_len  (len_eff),
    .req_size (size),
    .res      (scan)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if ((state == ST_RESULT) && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_RESULT) && out_free) begin
      m_tdata <= {1'b0, res_rd, res_pos};
      m_tuser <= res_found;
    end
  end

endmodule

// File: hdl/bbfa_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbfa_checker
// Port-level checks of the allocator core, bound to the top level.
// ----------------------------------------------------------------------------
module bbfa_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [7:0]  m_tdata,
  input logic        m_tuser,
  input logic        cfg_valid,
  input logic        cfg_ready
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  // a granted run never carries read data
  a_found_no_read: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata[6] == 1'b0)
    else $error("bit_read set on a granted allocate");

  // without a grant the position is zero
  a_miss_pos_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tdata[5:0] == 6'd0)
    else $error("position nonzero without a grant");

  // one item in flight: input closes after each transfer
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("second item taken while one is in flight");

  // configuration writes are always taken
  a_cfg_open: assert property (@(posedge clk) disable iff (rst)
    cfg_valid |-> cfg_ready)
    else $error("configuration write refused");

endmodule

bind bitmap_best_fit_allocator_core bbfa_checker u_bbfa_checker (
  .clk       (clk),
  .rst       (rst),
  .s_tvalid  (s_tvalid),
  .s_tready  (s_tready),
  .m_tvalid  (m_tvalid),
  .m_tready  (m_tready),
  .m_tdata   (m_tdata),
  .m_tuser   (m_tuser),
  .cfg_valid (cfg_valid),
  .cfg_ready (cfg_ready)
);
